>>> sv/rsv_pkg.sv
`timescale 1ns / 1ps

package rsv_pkg;

    localparam int MASK_W     = 8;
    localparam int TICK_W     = 32;
    localparam int CNT_W      = 4;
    localparam int BACKOFF_W  = 14;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 16;

    localparam logic [CNT_W-1:0] CNT_MAX = '1;

    typedef enum logic [1:0] {
        MODE_START = 2'd0,
        MODE_TICK  = 2'd1,
        MODE_CHECK = 2'd2,
        MODE_NOP   = 2'd3
    } t_mode;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_ENTRY_COUNT   = 3'd0,
        CFG_INIT_MASK     = 3'd1,
        CFG_STABLE_WINDOW = 3'd2,
        CFG_UNSTABLE_LIM  = 3'd3,
        CFG_MAX_RESTART   = 3'd4,
        CFG_BACKOFF_BASE  = 3'd5
    } t_cfg_idx;

    typedef struct packed {
        logic [3:0]  entry_count;
        logic [7:0]  initial_task_mask;
        logic [15:0] stable_window;
        logic [3:0]  unstable_limit;
        logic [2:0]  max_restart_count;
        logic [7:0]  backoff_base;
    } t_cfg;

    localparam t_cfg CFG_RESET = '{
        entry_count:       4'd0,
        initial_task_mask: 8'd0,
        stable_window:     16'd10,
        unstable_limit:    4'd3,
        max_restart_count: 3'd5,
        backoff_base:      8'd5
    };

    typedef struct packed {
        logic freed;
        logic restart;
        logic giveup_unstable;
        logic giveup_limit;
        logic spawn_attempt;
        logic spawn_done;
        logic active;
        logic pending;
    } t_lane_flags;

endpackage

>>> sv/rsv_if.sv
`timescale 1ns / 1ps

interface rsv_req_if;
    logic       valid;
    logic       ready;
    logic [1:0] mode;
    logic [7:0] exited_mask;
    logic [7:0] spawn_ok_mask;

    modport source (output valid, output mode, output exited_mask, output spawn_ok_mask,
                    input ready);
    modport sink   (input valid, input mode, input exited_mask, input spawn_ok_mask,
                    output ready);
endinterface

interface rsv_rsp_if;
    logic       valid;
    logic       ready;
    logic [7:0] freed_mask;
    logic [7:0] restart_mask;
    logic [7:0] giveup_unstable_mask;
    logic [7:0] giveup_limit_mask;
    logic [7:0] spawn_attempt_mask;
    logic [7:0] spawn_done_mask;
    logic [7:0] active_mask;
    logic [7:0] pending_mask;

    modport source (output valid, output freed_mask, output restart_mask,
                    output giveup_unstable_mask, output giveup_limit_mask,
                    output spawn_attempt_mask, output spawn_done_mask,
                    output active_mask, output pending_mask, input ready);
    modport sink   (input valid, input freed_mask, input restart_mask,
                    input giveup_unstable_mask, input giveup_limit_mask,
                    input spawn_attempt_mask, input spawn_done_mask,
                    input active_mask, input pending_mask, output ready);
endinterface

interface rsv_cfg_if;
    logic        valid;
    logic        ready;
    logic [2:0]  index;
    logic [15:0] data;

    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface

>>> sv/rsv_lane.sv
`timescale 1ns / 1ps

module rsv_lane (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_en,
    input  logic [1:0]            i_mode,
    input  logic                  i_exited,
    input  logic                  i_spawn_ok,
    input  logic                  i_init_active,
    input  logic                  i_init_unit,
    input  logic [31:0]           i_tick_next,
    input  logic [31:0]           i_tick_cur,
    input  rsv_pkg::t_cfg         i_cfg,
    output rsv_pkg::t_lane_flags  o_flags
);
    import rsv_pkg::*;

    logic                 r_active,  n_active;
    logic                 r_unit,    n_unit;
    logic                 r_pending, n_pending;
    logic [CNT_W-1:0]     r_restart, n_restart;
    logic [CNT_W-1:0]     r_unstab,  n_unstab;
    logic [BACKOFF_W-1:0] r_backoff, n_backoff;
    logic [TICK_W-1:0]    r_spawn_t, n_spawn_t;

    logic [TICK_W-1:0]    life;
    logic [CNT_W-1:0]     unstab_inc;
    logic [CNT_W-1:0]     restart_inc;
    logic [2:0]           shift_amt;
    t_lane_flags          flags;

    always_comb begin
        life        = i_tick_next - r_spawn_t;
        unstab_inc  = (life < 32'(i_cfg.stable_window))
                    ? ((r_unstab < CNT_MAX) ? r_unstab + 4'd1 : r_unstab)
                    : '0;
        restart_inc = (r_restart < CNT_MAX) ? r_restart + 4'd1 : r_restart;
        shift_amt   = restart_inc[2:0] - 3'd1;

        n_active  = r_active;
        n_unit    = r_unit;
        n_pending = r_pending;
        n_restart = r_restart;
        n_unstab  = r_unstab;
        n_backoff = r_backoff;
        n_spawn_t = r_spawn_t;
        flags     = '0;

        unique case (t_mode'(i_mode))
            MODE_START: begin
                n_active  = i_init_active;
                n_unit    = i_init_active & i_init_unit;
                n_pending = 1'b0;
                n_restart = '0;
                n_unstab  = '0;
                n_backoff = '0;
                n_spawn_t = '0;
            end
            MODE_TICK: begin
                if (r_active && !(r_unit && !i_exited)) begin
                    if (r_backoff != '0) begin
                        n_backoff = r_backoff - 14'd1;
                        if (r_backoff == 14'd1) begin
                            n_pending = 1'b1;
                        end
                    end else if (r_unit) begin
                        n_unstab = unstab_inc;
                        n_unit   = 1'b0;
                        flags.freed = 1'b1;
                        if (unstab_inc >= i_cfg.unstable_limit) begin
                            n_active = 1'b0;
                            flags.giveup_unstable = 1'b1;
                        end else begin
                            n_restart = restart_inc;
                            if (restart_inc > {1'b0, i_cfg.max_restart_count}) begin
                                n_active = 1'b0;
                                flags.giveup_limit = 1'b1;
                            end else begin
                                n_backoff = {6'd0, i_cfg.backoff_base} << shift_amt;
                                flags.restart = 1'b1;
                            end
                        end
                    end else begin
                        n_pending = 1'b1;
                    end
                end
            end
            MODE_CHECK: begin
                if (r_active && r_pending) begin
                    flags.spawn_attempt = 1'b1;
                    if (i_spawn_ok) begin
                        n_pending = 1'b0;
                        n_unit    = 1'b1;
                        n_spawn_t = i_tick_cur;
                        flags.spawn_done = 1'b1;
                    end
                end
            end
            MODE_NOP: begin
            end
            default: begin
            end
        endcase

        flags.active  = n_active;
        flags.pending = n_active & n_pending;
        o_flags       = flags;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_active  <= 1'b0;
            r_unit    <= 1'b0;
            r_pending <= 1'b0;
            r_restart <= '0;
            r_unstab  <= '0;
            r_backoff <= '0;
            r_spawn_t <= '0;
        end else if (i_en) begin
            r_active  <= n_active;
            r_unit    <= n_unit;
            r_pending <= n_pending;
            r_restart <= n_restart;
            r_unstab  <= n_unstab;
            r_backoff <= n_backoff;
            r_spawn_t <= n_spawn_t;
        end
    end

endmodule

>>> sv/rsv_merge.sv
`timescale 1ns / 1ps

module rsv_merge #(
    parameter int Entries = 8
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_accept,
    input  rsv_pkg::t_lane_flags i_flags [Entries],
    output logic                 o_ready,
    rsv_rsp_if.source            o_rsp
);
    import rsv_pkg::*;

    logic              r_valid;
    logic [MASK_W-1:0] r_freed, r_restart, r_gu, r_gl, r_att, r_done, r_act, r_pend;
    logic [MASK_W-1:0] n_freed, n_restart, n_gu, n_gl, n_att, n_done, n_act, n_pend;

    always_comb begin
        n_freed   = '0;
        n_restart = '0;
        n_gu      = '0;
        n_gl      = '0;
        n_att     = '0;
        n_done    = '0;
        n_act     = '0;
        n_pend    = '0;
        for (int i = 0; i < MASK_W && i < Entries; i++) begin
            n_freed[i]   = i_flags[i].freed;
            n_restart[i] = i_flags[i].restart;
            n_gu[i]      = i_flags[i].giveup_unstable;
            n_gl[i]      = i_flags[i].giveup_limit;
            n_att[i]     = i_flags[i].spawn_attempt;
            n_done[i]    = i_flags[i].spawn_done;
            n_act[i]     = i_flags[i].active;
            n_pend[i]    = i_flags[i].pending;
        end
    end

    assign o_ready = !r_valid || o_rsp.ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_accept) begin
            r_valid <= 1'b1;
        end else if (o_rsp.ready) begin
            r_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_accept) begin
            r_freed   <= n_freed;
            r_restart <= n_restart;
            r_gu      <= n_gu;
            r_gl      <= n_gl;
            r_att     <= n_att;
            r_done    <= n_done;
            r_act     <= n_act;
            r_pend    <= n_pend;
        end
    end

    assign o_rsp.valid                = r_valid;
    assign o_rsp.freed_mask           = r_freed;
    assign o_rsp.restart_mask         = r_restart;
    assign o_rsp.giveup_unstable_mask = r_gu;
    assign o_rsp.giveup_limit_mask    = r_gl;
    assign o_rsp.spawn_attempt_mask   = r_att;
    assign o_rsp.spawn_done_mask      = r_done;
    assign o_rsp.active_mask          = r_act;
    assign o_rsp.pending_mask         = r_pend;

endmodule

>>> sv/restart_supervisor_backoff_core.sv
// The result of an accepted request is registered and shows on o_rsp in the cycle after it is accepted.
// Throughput: one request per cycle while o_rsp is not stalled; all entries update at once in their lanes.
// A request is taken whenever the result register is empty or being drained.
// Reset (synchronous, active low) clears the table, the tick counter and the
// result valid flag, and loads the register defaults; no clearing pass follows.
`timescale 1ns / 1ps

module restart_supervisor_backoff_core #(
    parameter int ENTRIES = 8
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    rsv_cfg_if.sink    i_cfg,
    rsv_req_if.sink    i_req,
    rsv_rsp_if.source  o_rsp
);
    import rsv_pkg::*;

    t_cfg              r_cfg;
    logic [TICK_W-1:0] r_tick, n_tick;
    logic              accept;
    logic              merge_ready;
    t_lane_flags       lane_flags [ENTRIES];

    assign i_cfg.ready = 1'b1;
    assign i_req.ready = merge_ready;
    assign accept      = i_req.valid && merge_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg <= CFG_RESET;
        end else if (i_cfg.valid) begin
            unique case (i_cfg.index)
                CFG_ENTRY_COUNT:   r_cfg.entry_count       <= i_cfg.data[3:0];
                CFG_INIT_MASK:     r_cfg.initial_task_mask <= i_cfg.data[7:0];
                CFG_STABLE_WINDOW: r_cfg.stable_window     <= i_cfg.data;
                CFG_UNSTABLE_LIM:  r_cfg.unstable_limit    <= i_cfg.data[3:0];
                CFG_MAX_RESTART:   r_cfg.max_restart_count <= i_cfg.data[2:0];
                CFG_BACKOFF_BASE:  r_cfg.backoff_base      <= i_cfg.data[7:0];
                default: begin
                end
            endcase
        end
    end

    always_comb begin
        n_tick = r_tick;
        unique case (t_mode'(i_req.mode))
            MODE_START: n_tick = '0;
            MODE_TICK:  n_tick = r_tick + 32'd1;
            MODE_CHECK: n_tick = r_tick;
            MODE_NOP:   n_tick = r_tick;
            default:    n_tick = r_tick;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tick <= '0;
        end else if (accept) begin
            r_tick <= n_tick;
        end
    end

    for (genvar g = 0; g < ENTRIES; g++) begin : g_lane
        logic exited;
        logic spawn_ok;
        logic init_unit;
        logic init_active;

        if (g < MASK_W) begin : g_bits
            assign exited    = i_req.exited_mask[g];
            assign spawn_ok  = i_req.spawn_ok_mask[g];
            assign init_unit = r_cfg.initial_task_mask[g];
        end else begin : g_nobits
            assign exited    = 1'b0;
            assign spawn_ok  = 1'b0;
            assign init_unit = 1'b0;
        end

        assign init_active = 32'(g) < 32'(r_cfg.entry_count);

        rsv_lane u_lane (
            .i_clk         (i_clk),
            .i_rst_n       (i_rst_n),
            .i_en          (accept),
            .i_mode        (i_req.mode),
            .i_exited      (exited),
            .i_spawn_ok    (spawn_ok),
            .i_init_active (init_active),
            .i_init_unit   (init_unit),
            .i_tick_next   (n_tick),
            .i_tick_cur    (r_tick),
            .i_cfg         (r_cfg),
            .o_flags       (lane_flags[g])
        );
    end

    rsv_merge #(
        .Entries (ENTRIES)
    ) u_merge (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_accept (accept),
        .i_flags  (lane_flags),
        .o_ready  (merge_ready),
        .o_rsp    (o_rsp)
    );

endmodule
